// ===== rtl/core/cba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous block allocator package
// Shared widths, codes and word types of the first-fit block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

  // Field widths of the request, response and configuration words.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned SIZE_W   = 21;
  localparam int unsigned FIELD_W  = 10;
  localparam int unsigned COUNT_W  = 11;

  // Default parameter values.
  localparam int unsigned MAX_BLOCKS_DEF      = 1024;
  localparam int unsigned BLOCK_BYTES_DEF     = 1024;
  localparam int unsigned RESERVED_BLOCKS_DEF = 1;

  // Reset value of the data block count register.
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1023);

  // Request actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RESERVE = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  // Response status codes.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SIZE_W-1:0]   size_bytes;
    logic [FIELD_W-1:0]  range_first;
    logic [FIELD_W-1:0]  range_last;
  } req_t;

  typedef struct packed {
    logic               status;
    logic [FIELD_W-1:0] run_first;
    logic [FIELD_W-1:0] run_last;
  } rsp_t;

endpackage

// ===== rtl/core/contiguous_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous block allocator
// First-fit allocator of contiguous block runs over a free/used bitmap held
// in a single-port synchronous memory.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low, and exactly one
// response word follows, marked by a one-cycle done_o strobe that cannot be
// held off. After reset the block runs a clearing pass over the whole bitmap,
// one block per cycle, and stays busy meanwhile. An allocation walks the
// bitmap memory one block per cycle from block RESERVED_BLOCKS upwards until
// a long enough run is found or the data region is exhausted, then marks the
// blocks of the run used. A reserve or release marks each block of the range
// in turn. A zero-byte allocation, an empty range, a range that starts beyond
// the last block and an unused action answer straight from idle, with no scan
// or marking pass. The single bitmap port handles one block per cycle.
// ----------------------------------------------------------------------------
module contiguous_block_allocator #(
  parameter int unsigned MAX_BLOCKS      = cba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES     = cba_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned RESERVED_BLOCKS = cba_pkg::RESERVED_BLOCKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel.
  input  logic                         start,
  output logic                         busy,
  input  cba_pkg::req_t                req_i,
  // Response channel.
  output logic                         done_o,
  output cba_pkg::rsp_t                rsp_o,
  // Configuration write channel: the data block count register.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cba_pkg::COUNT_W-1:0]  cfg_data_i
);

  import cba_pkg::*;

  // Memory address width, and the width of the block counters, which must
  // hold MAX_BLOCKS itself as well as RESERVED_BLOCKS plus the largest count.
  localparam int unsigned AW    = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LIM_W = (CNT_W > COUNT_W + 1) ? CNT_W : COUNT_W + 1;
  // The byte accumulator stays below the request size plus one block.
  localparam int unsigned ACC_W = SIZE_W + 2;

  localparam logic [LIM_W-1:0] MaxIdx   = LIM_W'(MAX_BLOCKS - 1);
  localparam logic [LIM_W-1:0] MaxCnt   = LIM_W'(MAX_BLOCKS);
  localparam logic [LIM_W-1:0] ResFirst = LIM_W'(RESERVED_BLOCKS);
  localparam logic [ACC_W-1:0] BlkBytes = ACC_W'(BLOCK_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_MARK  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [LIM_W-1:0]   idx_q, idx_d;        // clear, scan issue or mark index
  logic [LIM_W-1:0]   end_q, end_d;        // scan limit or last block to mark
  logic               mark_free_q, mark_free_d;
  logic [ACC_W-1:0]   acc_q, acc_d;        // bytes covered by the current run
  logic [LIM_W-1:0]   run_start_q, run_start_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic               rd_vld_q, rd_vld_d;  // read data of rd_addr_q arrives
  logic [LIM_W-1:0]   rd_addr_q, rd_addr_d;
  logic               done_q, done_d;
  rsp_t               rsp_q, rsp_d;
  logic [COUNT_W-1:0] count_q;

  // Bitmap memory, one bit per block, 1 meaning free.
  logic               free_map_q [MAX_BLOCKS];
  logic               free_rd_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic               mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      free_map_q[mem_waddr] <= mem_wdata;
    end
    free_rd_q <= free_map_q[idx_q[AW-1:0]];
  end

  // Request decode helpers.
  logic [LIM_W-1:0] sum_lim, limit, rng_first, rng_last, rng_end;
  logic [ACC_W-1:0] acc_sum;
  logic [LIM_W-1:0] start_blk;

  assign sum_lim   = {{(LIM_W-COUNT_W){1'b0}}, count_q} + ResFirst;
  assign limit     = (sum_lim > MaxCnt) ? MaxCnt : sum_lim;
  assign rng_first = {{(LIM_W-FIELD_W){1'b0}}, req_i.range_first};
  assign rng_last  = {{(LIM_W-FIELD_W){1'b0}}, req_i.range_last};
  assign rng_end   = (rng_last > MaxIdx) ? MaxIdx : rng_last;
  assign acc_sum   = acc_q + BlkBytes;
  // A run starts at the block just read when no free block precedes it.
  assign start_blk = (acc_q == '0) ? rd_addr_q : run_start_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    end_d       = end_q;
    mark_free_d = mark_free_q;
    acc_d       = acc_q;
    run_start_d = run_start_q;
    size_d      = size_q;
    rd_vld_d    = 1'b0;
    rd_addr_d   = rd_addr_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wdata   = mark_free_q;

    case (state_q)
      S_CLEAR: begin
        // Every block starts free.
        mem_we    = 1'b1;
        mem_wdata = 1'b1;
        if (idx_q == MaxIdx) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          rsp_d.status    = STATUS_OK;
          rsp_d.run_first = '0;
          rsp_d.run_last  = '0;
          case (req_i.action)
            ACT_ALLOC: begin
              if (req_i.size_bytes == '0) begin
                // A zero-byte request needs no blocks and never matches.
                rsp_d.status = STATUS_NO_SPACE;
                done_d       = 1'b1;
              end else begin
                size_d  = req_i.size_bytes;
                idx_d   = ResFirst;
                end_d   = limit;
                acc_d   = '0;
                state_d = S_SCAN;
              end
            end
            ACT_RESERVE, ACT_RELEASE: begin
              if (rng_first > rng_last || rng_first > MaxIdx) begin
                done_d = 1'b1;
              end else begin
                idx_d       = rng_first;
                end_d       = rng_end;
                mark_free_d = (req_i.action == ACT_RELEASE);
                state_d     = S_MARK;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read while blocks remain below the limit.
        if (idx_q < end_q) begin
          rd_vld_d  = 1'b1;
          rd_addr_d = idx_q;
          idx_d     = idx_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (free_rd_q) begin
            run_start_d = start_blk;
            if (acc_sum >= {2'b00, size_q}) begin
              // Run long enough: drop the read in flight and mark it used.
              rd_vld_d        = 1'b0;
              idx_d           = start_blk;
              end_d           = rd_addr_q;
              mark_free_d     = 1'b0;
              rsp_d.status    = STATUS_OK;
              rsp_d.run_first = start_blk[FIELD_W-1:0];
              rsp_d.run_last  = rd_addr_q[FIELD_W-1:0];
              state_d         = S_MARK;
            end else begin
              acc_d = acc_sum;
            end
          end else begin
            acc_d = '0;
          end
        end else if (idx_q >= end_q) begin
          // Nothing left in flight or to read: no fitting run.
          rsp_d.status    = STATUS_NO_SPACE;
          rsp_d.run_first = '0;
          rsp_d.run_last  = '0;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end

      S_MARK: begin
        mem_we = 1'b1;
        if (idx_q == end_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      end_q       <= '0;
      mark_free_q <= 1'b0;
      acc_q       <= '0;
      run_start_q <= '0;
      rd_vld_q    <= 1'b0;
      rd_addr_q   <= '0;
      done_q      <= 1'b0;
      count_q     <= COUNT_RESET;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      mark_free_q <= mark_free_d;
      acc_q       <= acc_d;
      run_start_q <= run_start_d;
      rd_vld_q    <= rd_vld_d;
      rd_addr_q   <= rd_addr_d;
      done_q      <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    rsp_q  <= rsp_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  // A failed allocation never reports a run.
  a_fail_zero_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == STATUS_NO_SPACE |-> rsp_o.run_first == '0 &&
    rsp_o.run_last == '0)
    else $error("failed allocation reports a run");

  // The scan only reads the bitmap, so no read can meet a write.
  a_scan_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> !mem_we)
    else $error("bitmap written during a scan");

  // An accepted request either answers at once or keeps the block busy.
  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted request neither answered nor in progress");

endmodule
